// ===== hw/rtl/zrld_pkg.sv =====
// ----------------------------------------------------------------------------
// zrld_pkg
// Types and constants shared by the zero run-length decoder modules.
// ----------------------------------------------------------------------------
package zrld_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 7;
  localparam int unsigned FmtW   = 2;

  localparam logic [FmtW-1:0] FMT_V1    = 2'd1;
  localparam logic [FmtW-1:0] FMT_V2    = 2'd2;
  localparam logic [FmtW-1:0] FMT_RESET = FMT_V2;

  localparam logic [ByteW-1:0] MASK_LOW7 = 8'h7f;
  localparam logic [ByteW-1:0] MASK_LOW6 = 8'h3f;
  localparam logic [ByteW-1:0] MASK_LOW4 = 8'h0f;
  localparam logic [ByteW-1:0] MASK_ZRUN = 8'h07;

  // decode of one byte against the current state
  typedef struct packed {
    logic              emit;
    logic [ByteW-1:0]  value;
    logic [CountW-1:0] count;
    logic              err;
    logic [CountW-1:0] lit_next;
    logic              err_next;
  } dec_res_t;

endpackage

// ===== hw/rtl/zrld_decode.sv =====
// ----------------------------------------------------------------------------
// zrld_decode
// Combinational decode of one stream byte: literal pass, control byte
// decode for both formats, sticky error handling and next state.
// ----------------------------------------------------------------------------
module zrld_decode import zrld_pkg::*; (
  input  logic [ByteW-1:0]  code,
  input  logic              start,
  input  logic [FmtW-1:0]   fmt,
  input  logic [CountW-1:0] lit_left,
  input  logic              err_latched,
  output dec_res_t          res
);

  logic [CountW-1:0] lit_cur;
  logic              err_cur;
  logic [ByteW-1:0]  zeros;
  logic [ByteW-1:0]  lits;

  assign lit_cur = start ? '0 : lit_left;
  assign err_cur = start ? 1'b0 : err_latched;

  always_comb begin
    zeros = '0;
    lits  = '0;
    if (fmt == FMT_V2) begin
      if (code[7]) begin
        zeros = (code >> 4) & MASK_ZRUN;
        lits  = code & MASK_LOW4;
      end else if (code[6]) begin
        zeros = code & MASK_LOW6;
      end else begin
        lits = code;
      end
    end else begin
      if (code[7]) begin
        zeros = code & MASK_LOW7;
      end else begin
        lits = code;
      end
    end
  end

  always_comb begin
    res          = '0;
    res.lit_next = lit_cur;
    res.err_next = err_cur;
    if (err_cur) begin
      res.emit = 1'b1;
      res.err  = 1'b1;
    end else if (lit_cur != '0) begin
      res.emit     = 1'b1;
      res.value    = code;
      res.count    = CountW'(1);
      res.lit_next = lit_cur - CountW'(1);
    end else if ((code & MASK_LOW7) == '0) begin
      res.emit     = 1'b1;
      res.err      = 1'b1;
      res.err_next = 1'b1;
      res.lit_next = '0;
    end else begin
      res.lit_next = lits[CountW-1:0];
      res.emit     = (zeros != '0);
      res.count    = zeros[CountW-1:0];
    end
  end

endmodule

// ===== hw/rtl/zero_run_length_decoder.sv =====
// An input beat passes the input register and then the result register to become a result beat.
// Throughput: one byte per cycle; a stalled result holds the input stage.
// Bytes that end in no result (literal count loads, empty runs) are dropped.
// Reset (rst, synchronous): literal count and error cleared, format = 2.
// ----------------------------------------------------------------------------
// zero_run_length_decoder
// Zero run-length stream decoder: input register, decode, result register.
// ----------------------------------------------------------------------------
module zero_run_length_decoder import zrld_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [FmtW-1:0]   format_version,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ByteW-1:0]  code_byte,
  input  logic              stream_start,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ByteW-1:0]  out_value,
  output logic [CountW-1:0] repeat_count,
  output logic              decode_error
);

  logic [FmtW-1:0]   fmt;
  logic              in_q_valid;
  logic [ByteW-1:0]  in_q_code;
  logic              in_q_start;
  logic [CountW-1:0] lit_left;
  logic              err_latched;
  logic              adv;
  dec_res_t          res;

  assign cfg_ready = 1'b1;
  assign adv       = in_q_valid && (!out_valid || !out_stall);
  assign in_stall  = in_q_valid && !adv;

  zrld_decode u_dec (
    .code        (in_q_code),
    .start       (in_q_start),
    .fmt         (fmt),
    .lit_left    (lit_left),
    .err_latched (err_latched),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt         <= FMT_RESET;
      in_q_valid  <= 1'b0;
      out_valid   <= 1'b0;
      lit_left    <= '0;
      err_latched <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        fmt <= format_version;
      end
      if (!in_stall) begin
        in_q_valid <= in_valid;
      end
      if (adv) begin
        lit_left    <= res.lit_next;
        err_latched <= res.err_next;
        out_valid   <= res.emit;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_q_code  <= code_byte;
      in_q_start <= stream_start;
    end
    if (adv) begin
      out_value    <= res.value;
      repeat_count <= res.count;
      decode_error <= res.err;
    end
  end

endmodule

// ===== hw/rtl/zrld_checker.sv =====
// ----------------------------------------------------------------------------
// zrld_checker
// Port-level checks on the result beats of the decoder; bound to the top.
// ----------------------------------------------------------------------------
module zrld_checker import zrld_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [ByteW-1:0]  out_value,
  input logic [CountW-1:0] repeat_count,
  input logic              decode_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_value)
      && $stable(repeat_count) && $stable(decode_error))
    else $error("result beat changed while stalled");

  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && decode_error |-> out_value == '0 && repeat_count == '0)
    else $error("error beat carries data");

  a_count_nz: assert property (@(posedge clk) disable iff (rst)
    out_valid && !decode_error |-> repeat_count != '0)
    else $error("good beat with zero count");

  a_run_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !decode_error && repeat_count != CountW'(1) |-> out_value == '0)
    else $error("zero run with nonzero value");

endmodule

bind zero_run_length_decoder zrld_checker u_zrld_checker (.*);

// ===== test/zero_run_length_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_run_length_decoder_test
// Self-checking bench for the zero run-length decoder. A short table of
// directed bytes runs first: bad control bytes, the sticky error, empty runs
// and a stream restart in the middle of literals. Random streams follow under
// every format setting. Every result beat is checked against a local model of
// the decoder, and both sides stall at random.
// ----------------------------------------------------------------------------
module zero_run_length_decoder_test;
  import zrld_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned PHASE_BYTES  = 140;
  localparam int unsigned HOLD_CYCLES  = 150;

  // format codes outside 1 and 2 decode as format 1
  localparam logic [FmtW-1:0] FMT_ALT0 = 2'd0;
  localparam logic [FmtW-1:0] FMT_ALT3 = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0]  value;
    logic [CountW-1:0] count;
    logic              err;
  } run_beat_t;

  typedef enum logic [0:0] {ROW_BYTE, ROW_FMT} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [FmtW-1:0]   fmt;
    logic [ByteW-1:0]  code;
    logic              start;
    logic              typed;
    logic              t_has;
    run_beat_t         t_beat;
  } script_row_t;

  localparam logic      PRED     = 1'b0;
  localparam logic      TYPED    = 1'b1;
  localparam run_beat_t NO_BEAT  = '0;
  localparam run_beat_t BAD_BEAT = '{value: 8'h00, count: 7'd0, err: 1'b1};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [FmtW-1:0]   format_version = FMT_RESET;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ByteW-1:0]  code_byte = '0;
  logic              stream_start = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ByteW-1:0]  out_value;
  logic [CountW-1:0] repeat_count;
  logic              decode_error;

  // model state
  logic [CountW-1:0] lit_left = '0;
  logic              err_hold = 1'b0;
  logic [FmtW-1:0]   fmt_cur  = FMT_RESET;

  run_beat_t   runs_due [$];
  script_row_t script [0:25];
  logic [FmtW-1:0] phase_fmt [0:5];

  int unsigned failures  = 0;
  int unsigned cycles    = 0;
  int unsigned hold_left = 0;
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;
  bit          calm      = 1'b0;

  zero_run_length_decoder u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .format_version(format_version),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .code_byte     (code_byte),
    .stream_start  (stream_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .repeat_count  (repeat_count),
    .decode_error  (decode_error)
  );

  always #10 clk = ~clk;

  function automatic void flag_fail(string what, int unsigned want, int unsigned got);
    failures++;
    $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
  endfunction

  // returns 1 when the byte yields a result beat
  function automatic bit decode_byte(input logic [ByteW-1:0] c, input logic s,
                                     output run_beat_t r);
    logic [CountW-1:0] zeros;
    logic [CountW-1:0] lits;
    zeros = '0;
    lits  = '0;
    r     = '0;
    if (s) begin
      lit_left = '0;
      err_hold = 1'b0;
    end
    if (err_hold) begin
      r.err = 1'b1;
      return 1'b1;
    end
    if (lit_left != 0) begin
      lit_left = lit_left - 1'b1;
      r.value  = c;
      r.count  = 7'd1;
      return 1'b1;
    end
    if ((c & MASK_LOW7) == 0) begin
      err_hold = 1'b1;
      lit_left = '0;
      r.err    = 1'b1;
      return 1'b1;
    end
    if (fmt_cur == FMT_V2) begin
      if (c[7]) begin
        zeros = CountW'((c >> 4) & MASK_ZRUN);
        lits  = CountW'(c & MASK_LOW4);
      end else if (c[6]) begin
        zeros = CountW'(c & MASK_LOW6);
      end else begin
        lits = CountW'(c);
      end
    end else begin
      if (c[7]) zeros = CountW'(c & MASK_LOW7);
      else lits = CountW'(c);
    end
    lit_left = lits;
    if (zeros != 0) begin
      r.count = zeros;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [ByteW-1:0] next_control();
    int unsigned pick;
    int unsigned run;
    pick = $urandom_range(0, 15);
    run  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 6);
    if (pick == 0) return ($urandom_range(0, 1) != 0) ? 8'h80 : 8'h00;
    if (fmt_cur == FMT_V2) begin
      if (pick < 6) return {1'b1, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15))};
      if (pick < 9) return {2'b01, 6'($urandom_range(0, 63))};
      return 8'((run - 1) % 63 + 1);
    end
    if (pick < 7) return {1'b1, 7'(run)};
    return 8'(run);
  endfunction

  task automatic feed_byte(input logic [ByteW-1:0] c, input logic s, input logic typed,
                           input logic t_has, input run_beat_t t_beat);
    run_beat_t r;
    bit        has;
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    code_byte    <= c;
    stream_start <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = decode_byte(c, s, r);
    if (typed) begin
      has = t_has;
      r   = t_beat;
    end
    if (has) runs_due.push_back(r);
  endtask

  task automatic write_format(input logic [FmtW-1:0] f);
    in_valid <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk);
    // bytes without a result may still sit in the pipe
    repeat (6) @(posedge clk);
    cfg_valid      <= 1'b1;
    format_version <= f;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    fmt_cur = f;
  endtask

  task automatic run_phase(input int unsigned n);
    int unsigned k;
    logic [ByteW-1:0] c;
    logic s;
    for (k = 0; k < n; k++) begin
      s = 1'b0;
      if ($urandom_range(0, 19) == 0) begin
        c = 8'($urandom_range(0, 255));
        s = 1'($urandom_range(0, 1));
      end else if (err_hold) begin
        s = ($urandom_range(0, 3) != 0);
        c = next_control();
      end else if (lit_left != 0) begin
        c = 8'($urandom_range(0, 255));
      end else begin
        s = ($urandom_range(0, 15) == 0);
        c = next_control();
      end
      feed_byte(c, s, PRED, 1'b0, NO_BEAT);
    end
  endtask

  // receiver: stall pattern and result check
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (runs_due.size() == 0) begin
        flag_fail("no beat due, value", 0, out_value);
      end else begin
        if (runs_due[0].value !== out_value)
          flag_fail("out_value", runs_due[0].value, out_value);
        if (runs_due[0].count !== repeat_count)
          flag_fail("repeat_count", runs_due[0].count, repeat_count);
        if (runs_due[0].err !== decode_error)
          flag_fail("decode_error", runs_due[0].err, decode_error);
        void'(runs_due.pop_front());
      end
    end
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 38);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned i;
    script = '{
      '{ROW_BYTE, FMT_V2, 8'h00, 1'b1, TYPED, 1'b1, BAD_BEAT},
      '{ROW_BYTE, FMT_V2, 8'hff, 1'b0, TYPED, 1'b1, BAD_BEAT},
      '{ROW_BYTE, FMT_V2, 8'h80, 1'b1, TYPED, 1'b1, BAD_BEAT},
      '{ROW_BYTE, FMT_V2, 8'h85, 1'b1, TYPED, 1'b0, NO_BEAT},
      '{ROW_BYTE, FMT_V2, 8'h00, 1'b0, PRED,  1'b0, NO_BEAT},
      '{ROW_BYTE, FMT_V2, 8'hff, 1'b0, PRED,  1'b0, NO_BEAT},
      '{ROW_BYTE, FMT_V2, 8'h80, 1'b0, PRED,  1'b0, NO_BEAT},
      '{ROW_BYTE, FMT_V2, 8'h7f, 1'b0, PRED,  1'b0, NO_BEAT},
      '{ROW_BYTE, FMT_V2, 8'h01, 1'b0, PRED,  1'b0, NO_BEAT},
      '{ROW_BYTE, FMT_V2, 8'hf3, 1'b0, TYPED, 1'b1, '{8'h00, 7'd7, 1'b0}},
      '{ROW_BYTE, FMT_V2, 8'haa, 1'b0, PRED,  1'b0, NO_BEAT},
      '{ROW_BYTE, FMT_V2, 8'h55, 1'b0, PRED,  1'b0, NO_BEAT},
      '{ROW_BYTE, FMT_V2, 8'h00, 1'b0, PRED,  1'b0, NO_BEAT},
      '{ROW_BYTE, FMT_V2, 8'h7f, 1'b0, TYPED, 1'b1, '{8'h00, 7'd63, 1'b0}},
      '{ROW_BYTE, FMT_V2, 8'h40, 1'b0, TYPED, 1'b0, NO_BEAT},
      '{ROW_BYTE, FMT_V2, 8'h83, 1'b0, PRED,  1'b0, NO_BEAT},
      '{ROW_BYTE, FMT_V2, 8'h11, 1'b0, PRED,  1'b0, NO_BEAT},
      '{ROW_BYTE, FMT_V2, 8'h81, 1'b1, TYPED, 1'b0, NO_BEAT},
      '{ROW_BYTE, FMT_V2, 8'h22, 1'b0, PRED,  1'b0, NO_BEAT},
      '{ROW_FMT,  FMT_V1, 8'h00, 1'b0, PRED,  1'b0, NO_BEAT},
      '{ROW_BYTE, FMT_V1, 8'hff, 1'b1, TYPED, 1'b1, '{8'h00, 7'd127, 1'b0}},
      '{ROW_BYTE, FMT_V1, 8'h01, 1'b0, PRED,  1'b0, NO_BEAT},
      '{ROW_BYTE, FMT_V1, 8'h80, 1'b0, PRED,  1'b0, NO_BEAT},
      '{ROW_BYTE, FMT_V1, 8'h80, 1'b0, TYPED, 1'b1, BAD_BEAT},
      '{ROW_FMT,  FMT_ALT3, 8'h00, 1'b0, PRED, 1'b0, NO_BEAT},
      '{ROW_BYTE, FMT_ALT3, 8'h82, 1'b1, PRED, 1'b0, NO_BEAT}
    };
    phase_fmt = '{FMT_V1, FMT_ALT0, FMT_V2, FMT_ALT3, FMT_V2, FMT_V1};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // format is still at its reset value here
    for (i = 0; i < 26; i++) begin
      if (script[i].kind == ROW_FMT)
        write_format(script[i].fmt);
      else
        feed_byte(script[i].code, script[i].start, script[i].typed,
                  script[i].t_has, script[i].t_beat);
    end

    for (i = 0; i < 6; i++) begin
      write_format(phase_fmt[i]);
      calm     = (i == 3);
      hold_req = (i >= 2);
      run_phase(PHASE_BYTES);
    end

    in_valid <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
